>>> sv/ffba_pkg.sv
`timescale 1ns / 1ps
// Package for the first-fit block allocator: sizes, item types and codes.
// It depends on nothing; every module of the allocator imports it.
package ffba_pkg;

	localparam int NUM_BLOCKS = 256;
	localparam int NUM_FILES  = 64;
	localparam int NUM_PIDS   = 64;

	localparam int BLK_W = $clog2(NUM_BLOCKS);
	localparam int FID_W = $clog2(NUM_FILES);
	localparam int CNT_W = 9;
	localparam int CFG_W = 64;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_VALID_PID    = 2'd0;
	localparam logic [1:0] REG_REALTIME_PID = 2'd1;

	// Operation codes.
	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_DELETE  = 2'd1;
	localparam logic [1:0] OP_PRELOAD = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_PROC   = 3'd1;
	localparam logic [2:0] ST_NO_SPACE  = 3'd2;
	localparam logic [2:0] ST_MISSING   = 3'd3;
	localparam logic [2:0] ST_NOT_OWNER = 3'd4;
	localparam logic [2:0] ST_RANGE     = 3'd5;

	// One map entry: used flag and the tag of the file occupying the block.
	typedef struct packed {
		logic       used;
		logic [5:0] fid;
	} map_t;

	// Owner record: bit 6 marks a file without owner (preloaded).
	typedef struct packed {
		logic       none;
		logic [5:0] pid;
	} owner_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] pid;
		logic [5:0] file_id;
		logic [7:0] start_block;
		logic [8:0] block_count;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] alloc_start;
		logic [8:0] alloc_count;
		logic       block_used;
		logic [5:0] block_file;
	} rsp_t;

	// File table access from the controller.
	typedef struct packed {
		logic             rd_en;
		logic [FID_W-1:0] rd_addr;
		logic             wr_en;
		logic [FID_W-1:0] wr_addr;
		logic             wr_valid;
		owner_t           wr_owner;
	} ftab_ctl_t;

	typedef struct packed {
		logic   valid;
		owner_t owner;
	} ftab_rd_t;

endpackage

>>> sv/ffba_cell.sv
`timescale 1ns / 1ps
// One cell of the block map ring: holds a single map entry.
// Depends on ffba_pkg for the entry type.
module ffba_cell import ffba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  map_t din,
	output map_t dout
);

	map_t entry_q;

	// The entry moves one place along the ring on every shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

>>> sv/ffba_ftab.sv
`timescale 1ns / 1ps
// File table: valid bits in flip-flops and an owner memory with registered read.
// Depends on ffba_pkg for the table access types.
module ffba_ftab import ffba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ftab_ctl_t ctl,
	output ftab_rd_t  rd
);

	logic [NUM_FILES-1:0] valid_q;
	owner_t               owner_mem [NUM_FILES];
	logic                 rd_valid_q;
	owner_t               rd_owner_q;

	// Valid bits are cleared at reset, so no record reads as present.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_addr] <= ctl.wr_valid;
		end
	end

	// Owner memory: one write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			owner_mem[ctl.wr_addr] <= ctl.wr_owner;
		end
		if (ctl.rd_en) begin
			rd_owner_q <= owner_mem[ctl.rd_addr];
			rd_valid_q <= valid_q[ctl.rd_addr];
		end
	end

	assign rd.valid = rd_valid_q;
	assign rd.owner = rd_owner_q;

endmodule

>>> sv/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// First-fit block allocator. One item at a time: accepted only when idle.
// Read, delete and preload make one turn of the map ring; create makes a search
// turn, then a tagging turn if a run was found, and rejected requests skip the
// ring. In the search and tagging turns the ring shifts one block per cycle.
// Reset (arst_n low) frees every block, clears all file records and masks.
module first_fit_block_allocator_core import ffba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_wdata
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_FIND  = 5'b00100,
		S_WRITE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   valid_mask_q;
	logic [CFG_W-1:0]   rt_mask_q;
	req_t               item_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;
	logic [BLK_W-1:0]   pos_q;
	logic [CNT_W-1:0]   run_q;
	logic [BLK_W-1:0]   start_q;
	logic               found_q;
	logic               shift;
	logic               pass_end;
	map_t               ring [NUM_BLOCKS];
	map_t               head_new;
	logic               in_range;
	logic [CNT_W:0]     range_end;
	logic               pid_ok;
	logic               pid_rt;
	logic               fid_ok;
	logic               preload_fits;
	ftab_ctl_t          ft_ctl;
	ftab_rd_t           ft_rd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_mask_q <= '0;
			rt_mask_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_VALID_PID:    valid_mask_q <= cfg_wdata;
				REG_REALTIME_PID: rt_mask_q    <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// Block map ring: cell 0 is the head, the modified head re-enters at the tail.
	assign shift = (state_q == S_FIND) || (state_q == S_WRITE);

	for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
		map_t din;
		if (j == NUM_BLOCKS - 1) begin : g_tail
			assign din = head_new;
		end else begin : g_mid
			assign din = ring[j+1];
		end
		ffba_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.din    (din),
			.dout   (ring[j])
		);
	end

	// Request checks on the held item.
	assign pid_ok = ({1'b0, item_q.pid} < 7'(NUM_PIDS)) && valid_mask_q[item_q.pid];
	assign pid_rt = ({1'b0, item_q.pid} < 7'(NUM_PIDS)) && rt_mask_q[item_q.pid];
	assign fid_ok = {1'b0, item_q.file_id} < 7'(NUM_FILES);
	assign preload_fits = ({2'b00, item_q.start_block} + {1'b0, item_q.block_count})
		<= 11'(NUM_BLOCKS);

	// Range of blocks being tagged in the write turn.
	assign range_end = {2'b00, start_q} + {1'b0, item_q.block_count};
	assign in_range  = (pos_q >= start_q) && ({2'b00, pos_q} < range_end);
	assign pass_end  = pos_q == BLK_W'(NUM_BLOCKS - 1);

	// New value of the head entry as it goes round.
	always_comb begin
		head_new = ring[0];
		if (state_q == S_WRITE) begin
			case (item_q.opcode)
				OP_CREATE, OP_PRELOAD: begin
					if (in_range) begin
						head_new.used = 1'b1;
						head_new.fid  = item_q.file_id;
					end
				end
				OP_DELETE: begin
					if (ring[0].used && ring[0].fid == item_q.file_id) begin
						head_new = '0;
					end
				end
				default: ;
			endcase
		end
	end

	// File table access: read at acceptance, update at the end of a write turn.
	always_comb begin
		ft_ctl          = '0;
		ft_ctl.rd_en    = req_valid && req_ready;
		ft_ctl.rd_addr  = req.file_id[FID_W-1:0];
		ft_ctl.wr_addr  = item_q.file_id[FID_W-1:0];
		ft_ctl.wr_valid = item_q.opcode != OP_DELETE;
		ft_ctl.wr_owner.none = item_q.opcode == OP_PRELOAD;
		ft_ctl.wr_owner.pid  = item_q.pid;
		ft_ctl.wr_en    = (state_q == S_WRITE) && pass_end && (item_q.opcode != OP_READ);
	end

	ffba_ftab u_ftab (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ft_ctl),
		.rd     (ft_rd)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			run_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					pos_q   <= '0;
					run_q   <= '0;
					found_q <= 1'b0;
					state_q <= S_WRITE;
					case (item_q.opcode)
						OP_CREATE: begin
							if (!pid_ok || !fid_ok || item_q.block_count == '0) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_FIND;
							end
						end
						OP_DELETE: begin
							if (!pid_ok || !fid_ok || !ft_rd.valid ||
							    (!pid_rt && (ft_rd.owner != {1'b0, item_q.pid}))) begin
								state_q <= S_DONE;
							end
						end
						OP_PRELOAD: begin
							if (!fid_ok || !preload_fits) begin
								state_q <= S_DONE;
							end
						end
						default: ;
					endcase
				end
				S_FIND: begin
					pos_q <= pos_q + 1'b1;
					if (ring[0].used) begin
						run_q <= '0;
					end else begin
						run_q <= run_q + 1'b1;
						if (!found_q && (run_q + 1'b1 == item_q.block_count)) begin
							found_q <= 1'b1;
						end
					end
					if (pass_end) begin
						pos_q <= '0;
						if (found_q || (!ring[0].used &&
						    (run_q + 1'b1 == item_q.block_count))) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_WRITE: begin
					pos_q <= pos_q + 1'b1;
					if (pass_end) begin
						pos_q   <= '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item hold, run start and result fields.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		case (state_q)
			S_CHECK: begin
				res_q   <= '0;
				start_q <= item_q.start_block;
				case (item_q.opcode)
					OP_CREATE: begin
						if (!pid_ok) begin
							res_q.status <= ST_NO_PROC;
						end else if (!fid_ok) begin
							res_q.status <= ST_RANGE;
						end else if (item_q.block_count == '0) begin
							res_q.status <= ST_NO_SPACE;
						end
					end
					OP_DELETE: begin
						if (!pid_ok) begin
							res_q.status <= ST_NO_PROC;
						end else if (!fid_ok || !ft_rd.valid) begin
							res_q.status <= ST_MISSING;
						end else if (!pid_rt && (ft_rd.owner != {1'b0, item_q.pid})) begin
							res_q.status <= ST_NOT_OWNER;
						end
					end
					OP_PRELOAD: begin
						if (!fid_ok || !preload_fits) begin
							res_q.status <= ST_RANGE;
						end
					end
					default: ;
				endcase
			end
			S_FIND: begin
				if (!ring[0].used && !found_q && run_q == '0) begin
					start_q <= pos_q;
				end
				if (pass_end) begin
					if (found_q || (!ring[0].used &&
					    (run_q + 1'b1 == item_q.block_count))) begin
						res_q.alloc_count <= item_q.block_count;
					end else begin
						res_q.status <= ST_NO_SPACE;
					end
				end
			end
			S_WRITE: begin
				if (item_q.opcode == OP_CREATE) begin
					res_q.alloc_start <= start_q;
				end
				if (item_q.opcode == OP_READ && pos_q == item_q.start_block &&
				    ring[0].used) begin
					res_q.block_used <= 1'b1;
					res_q.block_file <= ring[0].fid;
				end
			end
			default: ;
		endcase
	end

	// Output register: a finished result waits here for the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sv/ffba_checker.sv
`timescale 1ns / 1ps
// Port checker for the allocator core, attached to it by the bind below.
// Depends on ffba_pkg for the item types and status codes.
module ffba_checker import ffba_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A stalled result item holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// The block takes one item at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while busy");

	// Only defined status codes are reported.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_RANGE)
		else $error("undefined status code");

	// A failed request allocates nothing and reports no occupant.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
			rsp.alloc_count == '0 && rsp.alloc_start == '0 && !rsp.block_used)
		else $error("failed request carries result data");

	// A successful create never reports a run past the end of the disk.
	a_alloc_fits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.alloc_count != '0 |->
			({2'b00, rsp.alloc_start} + {1'b0, rsp.alloc_count}) <= 11'(NUM_BLOCKS))
		else $error("allocation beyond the disk");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
